// ----- rtl/w3f_pkg.sv -----
// ----------------------------------------------------------------------------
// w3f_pkg
// shared types and constants of the 3x3 window image filter
// ----------------------------------------------------------------------------
package w3f_pkg;

    typedef logic [7:0]  chan_t;
    typedef logic [23:0] pixel_t;

    // filter modes
    localparam logic [1:0] MODE_BOX     = 2'd0;
    localparam logic [1:0] MODE_GAUSS   = 2'd1;
    localparam logic [1:0] MODE_SHARPEN = 2'd2;
    localparam logic [1:0] MODE_SOBEL   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_WIDTH     = 2'd2;
    localparam logic [1:0] REG_HEIGHT    = 2'd3;

    // squared gradient magnitude and its root
    localparam int SQ_W   = 21;
    localparam int ROOT_W = 11;

endpackage

// ----- rtl/w3f_isqrt.sv -----
// ----------------------------------------------------------------------------
// w3f_isqrt
// iterative floor square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module w3f_isqrt
    import w3f_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic            busy_reg;
    logic            done_reg;
    logic [SQ_W-1:0] rem_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] bit_reg;
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] rem_next;
    logic [SQ_W-1:0] res_next;

    always_comb
    begin
        trial = res_reg + bit_reg;
        if (rem_reg >= trial)
        begin
            rem_next = rem_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            rem_next = rem_reg;
            res_next = res_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg == SQ_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= value;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ----- rtl/window3x3_image_filter.sv -----
// ----------------------------------------------------------------------------
// window3x3_image_filter
// 3x3 window filter (box, gaussian, sharpen, sobel) on an rgb raster stream
// ----------------------------------------------------------------------------
// The pixel history sits in one ring memory of 2*MAX_WIDTH+3 words with a
// single read port, so a filtered pixel reads its nine window words one per
// cycle; in sobel mode the iterative square root then runs its 11 steps. A
// border or flushed word reads only its centre word, a pixel that yields no
// result yet is taken without leaving idle, and the receiver can stall any
// result. Results lag the input by frame_width+1 pixels; flush words drain
// that lag. The ring is not cleared after reset, so no clearing pass is
// needed.
module window3x3_image_filter
    import w3f_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  chan_t       in_red,
    input  chan_t       in_green,
    input  chan_t       in_blue,
    output logic        out_valid,
    input  logic        out_ready,
    output chan_t       out_red,
    output chan_t       out_green,
    output chan_t       out_blue,
    output logic        frame_last
);

    localparam int RING = 2 * MAX_WIDTH + 3;
    localparam int AW   = $clog2(RING);
    localparam int PW   = $clog2(RING + 1);
    localparam int XW   = AW + 2;
    localparam int WDW  = $clog2(MAX_WIDTH + 1);
    localparam int HDW  = $clog2(MAX_HEIGHT + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_SQGO  = 3'd4;
    localparam logic [2:0] S_ROOT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [3:0] TAP_CENTER = 4'd4;
    localparam logic [3:0] TAP_LAST   = 4'd8;

    // configuration
    logic [1:0]  mode_reg;
    chan_t       thr_reg;
    logic [10:0] fw_reg;
    logic [10:0] fh_reg;

    // control
    logic [2:0]    state_reg;
    logic [AW-1:0] wp_reg;
    logic [PW-1:0] pending_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [XW-1:0] base_reg;
    logic          single_reg;
    logic [3:0]    tap_reg;
    logic          lat_vld_reg;
    logic [3:0]    lat_idx_reg;
    logic          out_valid_reg;

    // payload
    pixel_t          ring_mem [RING];
    pixel_t          rd_data_reg;
    pixel_t          win_reg [9];
    logic [SQ_W-1:0] sq_reg;
    chan_t           res_r_reg, res_g_reg, res_b_reg;
    chan_t           out_r_reg, out_g_reg, out_b_reg;
    logic            last_reg;

    logic [WDW-1:0] eff_w;
    logic [HDW-1:0] eff_h;
    logic           accept;
    logic           col_end, row_end, border;
    logic [PW-1:0]  p1;
    logic           emit_px;
    logic [XW-1:0]  off, bk, bk_mod, ad, ad_mod;
    logic [AW-1:0]  rd_addr;
    logic           rd_en;
    logic           out_free;
    logic           root_done;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] mag;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (fw_reg == '0)
            eff_w = WDW'(1);
        else if (int'(fw_reg) > MAX_WIDTH)
            eff_w = WDW'(MAX_WIDTH);
        else
            eff_w = WDW'(fw_reg);
        if (fh_reg == '0)
            eff_h = HDW'(1);
        else if (int'(fh_reg) > MAX_HEIGHT)
            eff_h = HDW'(MAX_HEIGHT);
        else
            eff_h = HDW'(fh_reg);
    end

    always_comb
    begin
        col_end = (WDW'(col_reg) + WDW'(1)) >= eff_w;
        row_end = (HDW'(row_reg) + HDW'(1)) >= eff_h;
        border  = (col_reg == '0) || col_end || (row_reg == '0) || row_end;
        p1      = (pending_reg < PW'(RING)) ? pending_reg + PW'(1) : pending_reg;
        emit_px = XW'(p1) >= (XW'(eff_w) + XW'(2));
    end

    // window tap offset back from the base, row by row from the top left
    always_comb
    begin
        case (tap_reg)
            4'd0:    off = XW'(eff_w) + XW'(eff_w) + XW'(2);
            4'd1:    off = XW'(eff_w) + XW'(eff_w) + XW'(1);
            4'd2:    off = XW'(eff_w) + XW'(eff_w);
            4'd3:    off = XW'(eff_w) + XW'(2);
            4'd4:    off = XW'(eff_w) + XW'(1);
            4'd5:    off = XW'(eff_w);
            4'd6:    off = XW'(2);
            4'd7:    off = XW'(1);
            default: off = '0;
        endcase
        if (single_reg)
            off = '0;
        bk     = base_reg + off;
        bk_mod = (bk >= XW'(RING)) ? bk - XW'(RING) : bk;
        ad     = XW'(wp_reg) + XW'(RING - 1) - bk_mod;
        ad_mod = (ad >= XW'(RING)) ? ad - XW'(RING) : ad;
        rd_addr = ad_mod[AW-1:0];
        rd_en   = (state_reg == S_FETCH);
    end

    // ring memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (accept && !command)
            ring_mem[wp_reg] <= {in_blue, in_green, in_red};
        if (rd_en)
            rd_data_reg <= ring_mem[rd_addr];
        if (lat_vld_reg)
            win_reg[lat_idx_reg] <= rd_data_reg;
    end

    // filter arithmetic on the captured window
    logic [11:0] box_sum [3];
    logic [23:0] box_prod [3];
    logic [11:0] gau_sum [3];
    logic signed [12:0] shp [3];
    chan_t       calc_res [3];
    logic [9:0]  ht, hb, vr, vl;
    logic signed [11:0] hg, vg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            box_sum[k] = '0;
            for (int i = 0; i < 9; i++)
                box_sum[k] = box_sum[k] + 12'(win_reg[i][8*k +: 8]);
            // divide by 9 through a scaled reciprocal
            box_prod[k] = 24'(box_sum[k]) * 24'd3641;
            gau_sum[k] = 12'(win_reg[0][8*k +: 8]) + 12'(win_reg[2][8*k +: 8])
                       + 12'(win_reg[6][8*k +: 8]) + 12'(win_reg[8][8*k +: 8])
                       + ((12'(win_reg[1][8*k +: 8]) + 12'(win_reg[3][8*k +: 8])
                       + 12'(win_reg[5][8*k +: 8]) + 12'(win_reg[7][8*k +: 8])) << 1)
                       + (12'(win_reg[4][8*k +: 8]) << 2);
            shp[k] = 13'sd5 * $signed({5'd0, win_reg[4][8*k +: 8]})
                   - $signed({5'd0, win_reg[1][8*k +: 8]})
                   - $signed({5'd0, win_reg[3][8*k +: 8]})
                   - $signed({5'd0, win_reg[5][8*k +: 8]})
                   - $signed({5'd0, win_reg[7][8*k +: 8]});
            case (mode_reg)
                MODE_BOX:   calc_res[k] = box_prod[k][22:15];
                MODE_GAUSS: calc_res[k] = gau_sum[k][11:4];
                default:
                begin
                    if (shp[k] < 0)
                        calc_res[k] = '0;
                    else if (shp[k] > 13'sd255)
                        calc_res[k] = 8'hFF;
                    else
                        calc_res[k] = shp[k][7:0];
                end
            endcase
        end
        ht = 10'(win_reg[0][7:0]) + (10'(win_reg[1][7:0]) << 1) + 10'(win_reg[2][7:0]);
        hb = 10'(win_reg[6][7:0]) + (10'(win_reg[7][7:0]) << 1) + 10'(win_reg[8][7:0]);
        vr = 10'(win_reg[2][15:8]) + (10'(win_reg[5][15:8]) << 1) + 10'(win_reg[8][15:8]);
        vl = 10'(win_reg[0][15:8]) + (10'(win_reg[3][15:8]) << 1) + 10'(win_reg[6][15:8]);
        hg = $signed({2'b00, ht}) - $signed({2'b00, hb});
        vg = $signed({2'b00, vr}) - $signed({2'b00, vl});
    end

    w3f_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_SQGO),
        .value (sq_reg),
        .done  (root_done),
        .root  (root)
    );

    assign mag = (root > ROOT_W'(thr_reg)) ? root : '0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BOX;
            thr_reg  <= '0;
            fw_reg   <= 11'd1024;
            fh_reg   <= 11'd1024;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODE:      mode_reg <= cfg_data[1:0];
                REG_THRESHOLD: thr_reg  <= cfg_data[7:0];
                REG_WIDTH:     fw_reg   <= cfg_data;
                REG_HEIGHT:    fh_reg   <= cfg_data;
                default:       mode_reg <= mode_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            pending_reg   <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            single_reg    <= 1'b0;
            tap_reg       <= '0;
            lat_vld_reg   <= 1'b0;
            lat_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lat_vld_reg <= rd_en;
            lat_idx_reg <= single_reg ? TAP_CENTER : tap_reg;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    tap_reg <= '0;
                    if (accept)
                    begin
                        if (!command)
                        begin
                            wp_reg <= (wp_reg == AW'(RING - 1)) ? '0 : wp_reg + AW'(1);
                            if (emit_px)
                            begin
                                pending_reg <= p1 - PW'(1);
                                single_reg  <= border;
                                state_reg   <= S_FETCH;
                            end
                            else
                                pending_reg <= p1;
                        end
                        else if (pending_reg != '0)
                        begin
                            pending_reg <= pending_reg - PW'(1);
                            single_reg  <= 1'b1;
                            state_reg   <= S_FETCH;
                        end
                    end
                end
                S_FETCH:
                begin
                    tap_reg <= tap_reg + 4'd1;
                    if (single_reg || tap_reg == TAP_LAST)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN: state_reg <= S_CALC;
                S_CALC:
                    state_reg <= (!single_reg && mode_reg == MODE_SOBEL) ? S_SQGO : S_OUT;
                S_SQGO: state_reg <= S_ROOT;
                S_ROOT:
                    if (root_done)
                        state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (col_end)
                        begin
                            col_reg <= '0;
                            row_reg <= row_end ? '0 : row_reg + RW'(1);
                        end
                        else
                            col_reg <= col_reg + CW'(1);
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // window base and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!command)
                base_reg <= (emit_px && !border)
                          ? XW'(p1) - XW'(2) - XW'(eff_w)
                          : XW'(p1) - XW'(1);
            else
                base_reg <= XW'(pending_reg) - XW'(1);
        end
        if (state_reg == S_CALC)
        begin
            if (single_reg)
            begin
                res_r_reg <= win_reg[4][7:0];
                res_g_reg <= win_reg[4][15:8];
                res_b_reg <= win_reg[4][23:16];
            end
            else
            begin
                res_r_reg <= calc_res[0];
                res_g_reg <= calc_res[1];
                res_b_reg <= calc_res[2];
            end
            sq_reg <= SQ_W'(hg * hg) + SQ_W'(vg * vg);
        end
        if (state_reg == S_ROOT && root_done)
        begin
            res_r_reg <= (mag > ROOT_W'(255)) ? 8'hFF : mag[7:0];
            res_g_reg <= (mag > ROOT_W'(255)) ? 8'hFF : mag[7:0];
            res_b_reg <= (mag > ROOT_W'(255)) ? 8'hFF : mag[7:0];
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_r_reg <= res_r_reg;
            out_g_reg <= res_g_reg;
            out_b_reg <= res_b_reg;
            last_reg  <= col_end && row_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_r_reg;
    assign out_green  = out_g_reg;
    assign out_blue   = out_b_reg;
    assign frame_last = last_reg;

    // pending words never exceed the ring
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PW'(RING))
        else $error("pending count beyond ring size");

    // last window read lands in the drain cycle
    a_drain_data: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> lat_vld_reg)
        else $error("no read data in drain cycle");

    // root completes only while the sequencer waits for it
    a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == S_ROOT)
        else $error("square root done out of sequence");

    // a loaded result is presented in the next cycle
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_free |=> out_valid && state_reg == S_IDLE)
        else $error("result not presented");

endmodule
